// File: src/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types, constants and entity tables for the XML text escaper.
// ----------------------------------------------------------------------------
package xte_pkg;

    localparam int PADDR_W = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int POS_W   = 4;

    localparam logic [PADDR_W-1:0] ADDR_MASK_DH = 3'd0;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_SPC  = 8'h20;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_LIT   = 3'd1,
        K_AMP   = 3'd2,
        K_GT    = 3'd3,
        K_LT    = 3'd4,
        K_QUOT  = 3'd5,
        K_APOS  = 3'd6,
        K_DASH2 = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
    } out_word_t;

    // One classified input item: optional held hyphen, then a body string
    typedef struct packed {
        logic       lead;
        kind_t      kind;
        logic [7:0] lit;
        logic       fin;
    } job_t;

    function automatic logic [POS_W-1:0] body_len(input kind_t k);
        logic [POS_W-1:0] n;
        unique case (k)
            K_NONE:  n = 4'd0;
            K_LIT:   n = 4'd1;
            K_AMP:   n = 4'd5;
            K_GT:    n = 4'd4;
            K_LT:    n = 4'd4;
            K_QUOT:  n = 4'd6;
            K_APOS:  n = 4'd6;
            K_DASH2: n = 4'd10;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] body_char(input kind_t k, input logic [POS_W-1:0] i,
                                             input logic [7:0] lit);
        logic [7:0] s [10];
        logic [7:0] c;
        s = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        unique case (k)
            K_AMP:   s = '{"&", "a", "m", "p", ";", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            K_GT:    s = '{"&", "g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            K_LT:    s = '{"&", "l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            K_QUOT:  s = '{"&", "q", "u", "o", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00};
            K_APOS:  s = '{"&", "a", "p", "o", "s", ";", 8'h00, 8'h00, 8'h00, 8'h00};
            K_DASH2: s = '{"&", "#", "4", "5", ";", "&", "#", "4", "5", ";"};
            default: s = '{lit, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        endcase
        if (i < 4'd10)
        begin
            c = s[i];
        end
        else
        begin
            c = 8'h00;
        end
        return c;
    endfunction

endpackage

// File: src/xte_front.sv
// ----------------------------------------------------------------------------
// xte_front
// Classifies each input word into a job and tracks the held hyphen.
// ----------------------------------------------------------------------------
module xte_front
    import xte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mask_dh,
    input  in_word_t in_data,
    input  logic     accept,
    output job_t     job,
    output logic     job_valid
);

    logic pend_reg;
    logic pend_next;
    logic is_dash;
    logic is_ctrl;
    logic [7:0] b;

    always_comb
    begin
        b         = in_data.text_byte;
        is_dash   = (b == CH_DASH) && mask_dh;
        is_ctrl   = (b != 8'h00) && (b < CH_SPC);
        job.lead  = 1'b0;
        job.kind  = K_NONE;
        job.lit   = b;
        job.fin   = in_data.final_byte;
        pend_next = 1'b0;
        if (is_dash)
        begin
            if (pend_reg)
            begin
                job.kind = K_DASH2;
            end
            else if (in_data.final_byte)
            begin
                // held hyphen flushed at text end
                job.kind = K_LIT;
            end
            else
            begin
                pend_next = 1'b1;
            end
        end
        else
        begin
            job.lead = pend_reg;
            priority if (is_ctrl)        job.kind = K_NONE;
            else if (b == CH_AMP)        job.kind = K_AMP;
            else if (b == CH_GT)         job.kind = K_GT;
            else if (b == CH_LT)         job.kind = K_LT;
            else if (b == CH_QUOT)       job.kind = K_QUOT;
            else if (b == CH_APOS)       job.kind = K_APOS;
            else                         job.kind = K_LIT;
        end
        job_valid = job.lead || (job.kind != K_NONE) || job.fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

// File: src/xte_fifo.sv
// ----------------------------------------------------------------------------
// xte_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module xte_fifo
    import xte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic rd_valid
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/xte_back.sv
// ----------------------------------------------------------------------------
// xte_back
// Walks each job byte by byte into a one-word output register.
// ----------------------------------------------------------------------------
module xte_back
    import xte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_valid,
    output logic      job_pop,
    input  logic      pop,
    output logic      empty,
    output out_word_t out_data
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] body_idx;
    logic             out_valid_reg;
    logic             out_free;
    logic             emit;
    logic             last;
    out_word_t        word_next;
    out_word_t        out_data_reg;

    always_comb
    begin
        total    = body_len(job.kind) + POS_W'(job.lead);
        body_idx = pos_reg - POS_W'(job.lead);
        last     = (total == '0) || (pos_reg == total - 1'b1);
        out_free = !out_valid_reg || pop;
        emit     = job_valid && out_free;
        job_pop  = emit && last;
        pos_next = last ? '0 : pos_reg + 1'b1;

        word_next.has_byte = (total != '0);
        word_next.run_last = last;
        word_next.text_end = last && job.fin;
        if (total == '0)
        begin
            word_next.out_byte = 8'h00;
        end
        else if (job.lead && (pos_reg == '0))
        begin
            word_next.out_byte = CH_DASH;
        end
        else
        begin
            word_next.out_byte = body_char(job.kind, body_idx, job.lit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                pos_reg <= pos_next;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= word_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// File: src/xml_text_escaper.sv
// ----------------------------------------------------------------------------
// xml_text_escaper
// Streams text bytes in and their XML-escaped form out, one word per byte.
// ----------------------------------------------------------------------------
// Path: an accepted word is written into the job queue, and its first result
//   then passes through the output register.
// Throughput: one input word per cycle while each word yields at most one byte
//   and every result is popped; an entity word holds the back end for each of
//   its bytes while the four-entry job queue lets the front keep accepting.
// Reset (rst_n low, asynchronous): queue and output empty, no hyphen held,
//   masking off. No clearing pass; the block accepts words right after reset.
// ----------------------------------------------------------------------------
module xml_text_escaper
    import xte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  in_word_t           in_data,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output out_word_t          out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic mask_dh_reg;
    logic accept;
    logic fifo_full;
    logic front_valid;
    job_t front_job;
    job_t q_job;
    logic q_valid;
    logic q_pop;

    // Configuration: one register, word-aligned; upper slot reads as zero.
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == ADDR_MASK_DH[PADDR_W-1])
                  ? {31'b0, mask_dh_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_dh_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1] == ADDR_MASK_DH[PADDR_W-1]))
        begin
            mask_dh_reg <= pwdata[0];
        end
    end

    // Accept whenever the job queue has room; silent words just update state.
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    xte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mask_dh   (mask_dh_reg),
        .in_data   (in_data),
        .accept    (accept),
        .job       (front_job),
        .job_valid (front_valid)
    );

    xte_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && front_valid),
        .wr_data  (front_job),
        .full     (fifo_full),
        .rd_en    (q_pop),
        .rd_data  (q_job),
        .rd_valid (q_valid)
    );

    // Back end: expand each job into bytes, one per free output slot.
    xte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_data  (out_data)
    );

    // End of text always closes the run of its input word.
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_data.text_end) |-> out_data.run_last)
        else $error("text_end without run_last");

    // An empty marker is only ever the end of a text and carries a zero byte.
    a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_data.has_byte) |-> (out_data.text_end && out_data.out_byte == 8'h00))
        else $error("empty marker outside text end");

    // A job leaves the queue only as its last byte is issued.
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (!empty && out_data.run_last))
        else $error("job retired without run_last");

endmodule

// File: tb/xte_escape_check.sv
// ----------------------------------------------------------------------------
// xte_escape_check
// Watches the text, result and register channels of the XML text escaper,
// predicts the escaped byte stream and compares it word by word.
// ----------------------------------------------------------------------------
module xte_escape_check
    import xte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  in_word_t           in_data,
    input  logic               empty,
    input  logic               pop,
    input  out_word_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatches,
    output int                 words_due
);

    localparam logic [7:0] CTRL_MAX = 8'h1F;

    logic      mask_on;
    logic      hyphen_held;
    int        err_cnt;
    out_word_t escaped_due [$];
    out_word_t step_words [$];

    function automatic void emit_char(input logic [7:0] b);
        out_word_t w;
        w          = '0;
        w.out_byte = b;
        w.has_byte = 1'b1;
        step_words.push_back(w);
    endfunction

    function automatic void emit_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            emit_char(s[i]);
        end
    endfunction

    // Expand one text byte into its escaped words and queue them
    function automatic void escape_byte(input logic [7:0] b, input logic fin);
        out_word_t w;
        step_words.delete();
        if (b == CH_DASH && mask_on)
        begin
            if (hyphen_held)
            begin
                emit_text("&#45;&#45;");
                hyphen_held = 1'b0;
            end
            else
            begin
                hyphen_held = 1'b1;
            end
        end
        else
        begin
            if (hyphen_held)
            begin
                emit_char(CH_DASH);
                hyphen_held = 1'b0;
            end
            if (b != 8'h00 && b <= CTRL_MAX)
            begin
                // control byte: dropped
            end
            else if (b == CH_AMP)
                emit_text("&amp;");
            else if (b == CH_GT)
                emit_text("&gt;");
            else if (b == CH_LT)
                emit_text("&lt;");
            else if (b == CH_QUOT)
                emit_text("&quot;");
            else if (b == CH_APOS)
                emit_text("&apos;");
            else
                emit_char(b);
        end
        if (fin)
        begin
            if (hyphen_held)
            begin
                emit_char(CH_DASH);
                hyphen_held = 1'b0;
            end
            if (step_words.size() == 0)
            begin
                w = '0;
                step_words.push_back(w);
            end
        end
        if (step_words.size() > 0)
        begin
            w          = step_words.pop_back();
            w.run_last = 1'b1;
            w.text_end = fin;
            step_words.push_back(w);
        end
        foreach (step_words[i])
        begin
            escaped_due.push_back(step_words[i]);
        end
    endfunction

    task automatic note_mismatch(input out_word_t want, input logic have_want);
        err_cnt++;
        if (err_cnt <= 10)
        begin
            if (have_want)
                $display("mismatch: expected byte %h has %b last %b end %b, got byte %h has %b last %b end %b",
                         want.out_byte, want.has_byte, want.run_last, want.text_end,
                         out_data.out_byte, out_data.has_byte, out_data.run_last,
                         out_data.text_end);
            else
                $display("mismatch: nothing expected, got byte %h has %b last %b end %b",
                         out_data.out_byte, out_data.has_byte, out_data.run_last,
                         out_data.text_end);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            mask_on     = 1'b0;
            hyphen_held = 1'b0;
            err_cnt     = 0;
            escaped_due.delete();
            mismatches <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                if (escaped_due.size() == 0)
                begin
                    want = '0;
                    note_mismatch(want, 1'b0);
                end
                else
                begin
                    want = escaped_due.pop_front();
                    if (out_data.out_byte !== want.out_byte
                        || out_data.has_byte !== want.has_byte
                        || out_data.run_last !== want.run_last
                        || out_data.text_end !== want.text_end)
                        note_mismatch(want, 1'b1);
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_MASK_DH)
                mask_on = pwdata[0];
            if (push && !full)
                escape_byte(in_data.text_byte, in_data.final_byte);
            mismatches <= err_cnt;
            words_due  <= escaped_due.size();
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes, result pops and mask register writes into the XML text
// escaper; a separate checker predicts and compares the escaped stream.
// ----------------------------------------------------------------------------
module testbench;
    import xte_pkg::*;

    localparam logic [7:0] CTRL_MIN = 8'h01;
    localparam logic [7:0] CTRL_MAX = 8'h1F;
    localparam int         PHASES   = 9;
    localparam int         PER_PHASE = 50;
    localparam int         SETTLE_CYCLES = 16;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               push     = 1'b0;
    logic               full;
    in_word_t           in_data  = '0;
    logic               empty;
    logic               pop      = 1'b0;
    out_word_t          out_data;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 mismatch_count;
    int                 words_outstanding;
    bit                 steady;

    xml_text_escaper dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    xte_escape_check u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_data    (in_data),
        .empty      (empty),
        .pop        (pop),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatch_count),
        .words_due  (words_outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Weight the text toward hyphens, entity characters and control bytes
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return CH_DASH;
        if (r < 40)
        begin
            case ($urandom_range(0, 4))
                0:       return CH_AMP;
                1:       return CH_GT;
                2:       return CH_LT;
                3:       return CH_QUOT;
                default: return CH_APOS;
            endcase
        end
        if (r < 50)
            return 8'($urandom_range(CTRL_MIN, CTRL_MAX));
        if (r < 54)
            return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Hold push until the word is taken, then maybe idle for a while
    task automatic feed(input logic [7:0] b, input logic fin);
        in_word_t w;
        int       gap;
        w.text_byte  = b;
        w.final_byte = fin;
        push    <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            push    <= 1'b0;
            in_data <= in_word_t'($urandom());
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop feeding, wait for every expected word, then let the job queue empty
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (words_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic on);
        logic [31:0] wd;
        wd    = $urandom();
        wd[0] = on;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MASK_DH;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: pop in bursts of random length with random stalls between
    initial
    begin
        int busy;
        int idle;
        @(posedge clk);
        forever
        begin
            busy = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 8);
            pop <= 1'b1;
            repeat (busy) @(posedge clk);
            idle = pick_gap();
            if (idle > 0)
            begin
                pop <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int       left_in_text;
        logic     fin;
        logic [7:0] b;

        steady = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Masking off out of reset: extremes, drops and every entity
        feed(8'h00, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'h80, 1'b0);
        feed(CH_SPC, 1'b0);
        feed(CTRL_MIN, 1'b0);
        feed(CTRL_MAX, 1'b1);       // silent last byte gives the empty marker
        feed(CH_AMP, 1'b0);
        feed(CH_GT, 1'b0);
        feed(CH_LT, 1'b0);
        feed(CH_QUOT, 1'b0);
        feed(CH_APOS, 1'b1);
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b1);        // hyphens pass through unmasked
        settle();

        // Masking on: pairs, lone hyphens, hyphen before a control byte
        write_mask(1'b1);
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b0);
        feed(8'h61, 1'b0);
        feed(CH_DASH, 1'b0);
        feed(8'h05, 1'b0);
        feed(CH_DASH, 1'b1);        // held hyphen flushed at text end
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b1);        // pair closes the text
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b0);
        feed(CH_DASH, 1'b0);
        feed(8'h0A, 1'b1);          // control at the end still flushes the hyphen
        feed(CTRL_MAX, 1'b1);
        feed(CH_DASH, 1'b0);
        settle();

        // Drop masking with a hyphen still held
        write_mask(1'b0);
        feed(8'h41, 1'b1);
        settle();

        // Random texts, one mask setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                write_mask(1'b1);
            else if (ph == 1)
                write_mask(1'b0);
            else
                write_mask(1'($urandom_range(0, 1)));
            steady       = ($urandom_range(0, 3) == 0);
            left_in_text = 0;
            for (int k = 0; k < PER_PHASE; k++)
            begin
                if (left_in_text == 0)
                    left_in_text = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                b   = pick_text_byte();
                // Close the text on its last byte, with a rare early end as noise
                fin = (left_in_text == 1) || ($urandom_range(0, 49) == 0);
                left_in_text = fin ? 0 : left_in_text - 1;
                feed(b, fin);
            end
            settle();
        end

        // Give any stray word time to show up
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
